/* rtl/masrs_pkg.sv */
// Package for the multi-axis stepper ramp scheduler.
// Shared constants and the divider status type; no dependencies.
`default_nettype none
package masrs_pkg;

  localparam int unsigned AXES_DEF      = 5;
  localparam int unsigned STEP_BITS_DEF = 23;

  // fixed field widths
  localparam int unsigned POS_W   = 32;
  localparam int unsigned FX_W    = 32;
  localparam int unsigned CD_W    = 24;
  localparam int unsigned IV_W    = 16;
  localparam int unsigned CNT_IN_W = 24;
  localparam int unsigned SCALE_RESET = 256;

  // input action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

/* rtl/masrs_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on masrs_pkg for the status type.
`default_nettype none
module masrs_div #(
  parameter int unsigned DDW = 57,
  parameter int unsigned DSW = 25
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [DDW-1:0]      dividend_i,
  input  wire logic [DSW-1:0]      divisor_i,
  output masrs_pkg::div_stat_t     stat_o,
  output logic      [DDW-1:0]      quotient_o
);
  import masrs_pkg::*;

  localparam int unsigned CW = $clog2(DDW + 1);

  logic [DSW:0]   rem_q, rem_d;
  logic [DDW-1:0] quo_q, quo_d;
  logic [DSW-1:0] dvs_q, dvs_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [DSW:0]   rem_sh;

  // one shift-subtract step per cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[DSW-1:0], quo_q[DDW-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CW'(DDW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        quo_d = {quo_q[DDW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DDW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

  // done only follows a running division
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without busy");
  // no restart while running
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  // remainder stays below divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < {1'b0, dvs_q}) else $error("divider remainder out of range");

endmodule
`default_nettype wire

/* rtl/multi_axis_stepper_ramp_scheduler.sv */
// Multi-axis stepper ramp scheduler, top level.
// Depends on masrs_pkg and masrs_div.
//
// Usage: one request on the input channel is either a time-base tick or a
// move load for one axis. Every request gives exactly one result: the step
// pulses of this tick, stored directions, busy axes, the position of the
// named axis (0 if out of range) and an all-done flag.
// Each request sweeps all axes one after another through one shared
// multiplier and one shared bit-serial divider. An idle axis only passes
// S_EVAL and S_NEXT; a load of the named axis and a cruising step add
// S_SCALE and S_CD; an accelerating step also waits in S_DIV on the divider
// (DDW = 34+STEP_BITS dividend bits, 57 at the default), and a decelerating
// one goes through S_MUL first. A request is longest when every axis decelerates.
// The input is not ready while a sweep runs. The result sits in an output
// register; the next request is accepted while it waits, and a finished
// sweep holds until the receiver takes the previous result.
// Reset clears every axis: position 0, not busy, scale 1.0.
`default_nettype none
module multi_axis_stepper_ramp_scheduler #(
  parameter int unsigned AXES      = masrs_pkg::AXES_DEF,
  parameter int unsigned STEP_BITS = masrs_pkg::STEP_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            action_i,
  input  wire logic [2:0]                      axis_i,
  input  wire logic signed [masrs_pkg::CNT_IN_W-1:0] step_count_i,
  input  wire logic [masrs_pkg::IV_W-1:0]      start_interval_i,
  input  wire logic [masrs_pkg::IV_W-1:0]      min_interval_i,
  input  wire logic [masrs_pkg::IV_W-1:0]      speed_scale_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [AXES-1:0]                      step_mask_o,
  output logic [AXES-1:0]                      dir_mask_o,
  output logic [AXES-1:0]                      busy_mask_o,
  output logic signed [masrs_pkg::POS_W-1:0]   axis_position_o,
  output logic                                 all_done_o
);
  import masrs_pkg::*;

  localparam int unsigned SW  = STEP_BITS;
  localparam int unsigned NW  = SW + 2;
  localparam int unsigned MBW = (NW > IV_W) ? NW : IV_W;
  localparam int unsigned PW  = FX_W + MBW;
  localparam int unsigned IW  = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [SW-1:0] LIM = {SW{1'b1}};
  localparam logic [PW-1:0] CD_MAX = PW'({CD_W{1'b1}});
  localparam logic [PW-1:0] FX_MAX = PW'({FX_W{1'b1}});

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_CD    = 3'd5;
  localparam logic [2:0] S_NEXT  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // per-axis state
  logic [POS_W-1:0] pos_q   [AXES];
  logic [SW-1:0]    ts_q    [AXES];
  logic [SW-1:0]    sd_q    [AXES];
  logic [SW-1:0]    rs_q    [AXES];
  logic [SW-1:0]    ri_q    [AXES];
  logic [FX_W-1:0]  ifx_q   [AXES];
  logic [CD_W-1:0]  cd_q    [AXES];
  logic [IV_W-1:0]  flr_q   [AXES];
  logic [IV_W-1:0]  scl_q   [AXES];
  logic [AXES-1:0]  dir_q;
  logic [AXES-1:0]  busy_q;

  // sequencer and request registers
  logic [2:0]       state_q;
  logic [IW-1:0]    idx_q;
  logic             act_q;
  logic [2:0]       axis_q;
  logic [CNT_IN_W-1:0] cnt_q;
  logic [IV_W-1:0]  start_q, minv_q, sclin_q;
  logic             dec_q;
  logic [SW-1:0]    n_q;
  logic [FX_W-1:0]  d_q;
  logic [PW-1:0]    prod_q;
  logic [AXES-1:0]  stepm_q;
  logic [POS_W-1:0] rpos_q;

  // output register
  logic             ovalid_q;
  logic [AXES-1:0]  ostep_q, odir_q, obusy_q;
  logic [POS_W-1:0] opos_q;
  logic             odone_q;

  // divider
  logic             div_start;
  logic [PW-1:0]    div_dvd;
  logic [NW-1:0]    div_dvs;
  div_stat_t        div_stat;
  logic [PW-1:0]    div_quo;

  masrs_div #(.DDW(PW), .DSW(NW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // current-axis view
  logic             match;
  logic [CD_W-1:0]  cd_dec;
  logic [SW-1:0]    sd_new, ri_inc;
  logic             do_step, accel, decel;
  assign match  = ({{(32-3){1'b0}}, axis_q} == 32'(idx_q));
  assign cd_dec = (cd_q[idx_q] != '0) ? cd_q[idx_q] - CD_W'(1) : cd_q[idx_q];
  assign do_step = busy_q[idx_q] && (cd_dec == '0);
  assign sd_new = (sd_q[idx_q] < ts_q[idx_q]) ? sd_q[idx_q] + SW'(1) : sd_q[idx_q];
  assign ri_inc = (ri_q[idx_q] < LIM) ? ri_q[idx_q] + SW'(1) : ri_q[idx_q];
  assign accel  = (rs_q[idx_q] == '0);
  assign decel  = !accel && (sd_new >= ts_q[idx_q] - rs_q[idx_q]) && (ri_q[idx_q] != '0);

  // shared multiplier: ramp factor or speed scale
  logic [MBW-1:0]   mul_b;
  logic [PW-1:0]    mul_p;
  assign mul_b = (state_q == S_MUL) ? MBW'({n_q, 2'b01}) : MBW'(scl_q[idx_q]);
  assign mul_p = PW'(d_q) * PW'(mul_b);

  // divider request
  always_comb begin
    div_start = 1'b0;
    div_dvd   = PW'({ifx_q[idx_q], 1'b0});
    div_dvs   = {ri_inc, 2'b01};
    if (state_q == S_EVAL && act_q == ACT_TICK && do_step && accel) begin
      div_start = 1'b1;
    end else if (state_q == S_MUL) begin
      div_start = 1'b1;
      div_dvd   = mul_p;
      div_dvs   = {n_q, 2'b00} - NW'(1);
    end
  end

  // load decode
  logic [CNT_IN_W-1:0] mag24;
  logic [31:0]         mag32, lim32;
  logic [SW-1:0]       mag;
  assign mag24 = cnt_q[CNT_IN_W-1] ? (~cnt_q + CNT_IN_W'(1)) : cnt_q;
  assign mag32 = 32'(mag24);
  assign lim32 = 32'(LIM);
  assign mag   = (mag32 > lim32) ? LIM : mag32[SW-1:0];

  // end-of-divide interval
  logic [FX_W-1:0] d_acc, d_dec, flr_fx;
  assign flr_fx = {flr_q[idx_q], 16'b0};
  assign d_acc  = d_q - div_quo[FX_W-1:0];
  assign d_dec  = (div_quo > FX_MAX) ? {FX_W{1'b1}} : div_quo[FX_W-1:0];

  // scaled countdown
  logic [PW-1:0]   cd_sh;
  logic [CD_W-1:0] cd_new;
  assign cd_sh  = prod_q >> 24;
  assign cd_new = (cd_sh > CD_MAX) ? {CD_W{1'b1}} :
                  (cd_sh == '0) ? CD_W'(1) : cd_sh[CD_W-1:0];

  logic last;
  assign last = (idx_q == IW'(AXES - 1));

  // sequencer and axis state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      dir_q    <= '0;
      busy_q   <= '0;
      ovalid_q <= 1'b0;
      stepm_q  <= '0;
      rpos_q   <= '0;
      d_q      <= '0;
      n_q      <= '0;
      dec_q    <= 1'b0;
      prod_q   <= '0;
      for (int i = 0; i < AXES; i++) begin
        pos_q[i] <= '0; ts_q[i] <= '0; sd_q[i] <= '0; rs_q[i] <= '0;
        ri_q[i]  <= '0; ifx_q[i] <= '0; cd_q[i] <= '0; flr_q[i] <= '0;
        scl_q[i] <= IV_W'(SCALE_RESET);
      end
    end else begin
      // result register: load a finished sweep, or drain to the receiver
      if (state_q == S_OUT && (!ovalid_q || out_ready_i)) ovalid_q <= 1'b1;
      else if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q   <= '0;
            stepm_q <= '0;
            rpos_q  <= '0;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_q <= S_NEXT;
          if (act_q == ACT_LOAD) begin
            if (match) begin
              dir_q[idx_q]  <= cnt_q[CNT_IN_W-1];
              ts_q[idx_q]   <= mag;
              sd_q[idx_q]   <= '0;
              rs_q[idx_q]   <= '0;
              ri_q[idx_q]   <= '0;
              flr_q[idx_q]  <= minv_q;
              scl_q[idx_q]  <= sclin_q;
              busy_q[idx_q] <= (mag != '0);
              d_q           <= {start_q, 16'b0};
              state_q       <= S_SCALE;
            end
          end else if (busy_q[idx_q]) begin
            cd_q[idx_q] <= cd_dec;
            if (do_step) begin
              stepm_q[idx_q] <= 1'b1;
              sd_q[idx_q]    <= sd_new;
              if (sd_q[idx_q] < ts_q[idx_q]) begin
                pos_q[idx_q] <= dir_q[idx_q] ? pos_q[idx_q] - POS_W'(1)
                                             : pos_q[idx_q] + POS_W'(1);
                if (sd_new >= ts_q[idx_q]) busy_q[idx_q] <= 1'b0;
              end
              d_q <= ifx_q[idx_q];
              if (accel) begin
                ri_q[idx_q] <= ri_inc;
                dec_q       <= 1'b0;
                state_q     <= S_DIV;
              end else if (decel) begin
                n_q     <= ri_q[idx_q];
                dec_q   <= 1'b1;
                state_q <= S_MUL;
              end else begin
                state_q <= S_SCALE;
              end
            end
          end
        end
        S_MUL: state_q <= S_DIV;
        S_DIV: begin
          if (div_stat.done) begin
            if (dec_q) begin
              d_q         <= d_dec;
              ri_q[idx_q] <= ri_q[idx_q] - SW'(1);
            end else begin
              d_q <= (d_acc <= flr_fx) ? flr_fx : d_acc;
              if (d_acc <= flr_fx || sd_q[idx_q] >= (ts_q[idx_q] >> 1))
                rs_q[idx_q] <= sd_q[idx_q];
            end
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          prod_q  <= mul_p;
          state_q <= S_CD;
        end
        S_CD: begin
          ifx_q[idx_q] <= d_q;
          cd_q[idx_q]  <= cd_new;
          state_q      <= S_NEXT;
        end
        S_NEXT: begin
          if (match) rpos_q <= pos_q[idx_q];
          if (last) state_q <= S_OUT;
          else begin
            idx_q   <= idx_q + IW'(1);
            state_q <= S_EVAL;
          end
        end
        S_OUT: begin
          if (!ovalid_q || out_ready_i) begin
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // request capture and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      act_q   <= action_i;
      axis_q  <= axis_i;
      cnt_q   <= step_count_i;
      start_q <= start_interval_i;
      minv_q  <= min_interval_i;
      sclin_q <= speed_scale_i;
    end
    if (state_q == S_OUT && (!ovalid_q || out_ready_i)) begin
      ostep_q <= stepm_q;
      odir_q  <= dir_q;
      obusy_q <= busy_q;
      opos_q  <= rpos_q;
      odone_q <= (busy_q == '0);
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = ovalid_q;
  assign step_mask_o     = ostep_q;
  assign dir_mask_o      = odir_q;
  assign busy_mask_o     = obusy_q;
  assign axis_position_o = opos_q;
  assign all_done_o      = odone_q;

  // result flag agrees with mask
  a_done_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (all_done_o == (busy_mask_o == '0))) else $error("all_done mismatch");
  // divider runs only while waiting on it
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == S_DIV) else $error("divider busy outside divide");
  // sweep index stays in range
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(idx_q) < AXES) else $error("axis index out of range");

endmodule
`default_nettype wire

/* sim/tb_multi_axis_stepper_ramp_scheduler.sv */
// Testbench for the multi-axis stepper ramp scheduler: drives ticks and move
// loads with random gaps and checks every result against an internal model.
// Depends on masrs_pkg and the scheduler RTL.
`timescale 1ns / 1ps
module tb_multi_axis_stepper_ramp_scheduler;
  import masrs_pkg::*;

  localparam int unsigned NAX      = AXES_DEF;
  localparam int unsigned SBITS    = STEP_BITS_DEF;
  localparam int unsigned WDOG_MAX = 20000;
  localparam logic [31:0] STEP_LIM = (32'd1 << SBITS) - 32'd1;
  localparam logic [31:0] CD_SAT   = 32'hFF_FFFF;

  typedef struct packed {
    logic [NAX-1:0]    step_mask;
    logic [NAX-1:0]    dir_mask;
    logic [NAX-1:0]    busy_mask;
    logic [POS_W-1:0]  position;
    logic              all_done;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic action_i = ACT_TICK;
  logic [2:0] axis_i = '0;
  logic signed [CNT_IN_W-1:0] step_count_i = '0;
  logic [IV_W-1:0] start_interval_i = '0;
  logic [IV_W-1:0] min_interval_i = '0;
  logic [IV_W-1:0] speed_scale_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [NAX-1:0] step_mask_o, dir_mask_o, busy_mask_o;
  logic signed [POS_W-1:0] axis_position_o;
  logic all_done_o;

  always #1 clk_i = ~clk_i;

  multi_axis_stepper_ramp_scheduler i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .axis_i, .step_count_i,
    .start_interval_i, .min_interval_i, .speed_scale_i, .out_valid_o, .out_ready_i,
    .step_mask_o, .dir_mask_o, .busy_mask_o, .axis_position_o, .all_done_o
  );

  // per-axis motion state of the model
  logic [31:0] m_pos   [NAX];
  logic        m_dir   [NAX];
  logic [31:0] m_total [NAX];
  logic [31:0] m_done  [NAX];
  logic [31:0] m_ramp  [NAX];
  logic [31:0] m_idx   [NAX];
  logic [31:0] m_ivfx  [NAX];
  logic [31:0] m_cd    [NAX];
  logic [15:0] m_floor [NAX];
  logic [15:0] m_scale [NAX];
  logic        m_busy  [NAX];

  sched_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;

  function automatic logic [31:0] scaled_countdown(int a);
    logic [63:0] c;
    c = ({32'd0, m_ivfx[a]} * {48'd0, m_scale[a]}) >> 24;
    if (c > CD_SAT) c = CD_SAT;
    if (c == 0) c = 1;
    return c[31:0];
  endfunction

  // one step pulse: move, then accelerate, cruise or decelerate
  function automatic void step_one_axis(int a);
    logic [63:0] d, floor_fx, n;
    d = m_ivfx[a];
    floor_fx = {32'd0, m_floor[a]} << 16;
    if (m_done[a] < m_total[a]) begin
      m_done[a]++;
      m_pos[a] = m_dir[a] ? m_pos[a] - 1 : m_pos[a] + 1;
      if (m_done[a] >= m_total[a]) m_busy[a] = 1'b0;
    end
    if (m_ramp[a] == 0) begin
      if (m_idx[a] < STEP_LIM) m_idx[a]++;
      n = m_idx[a];
      d = d - (2 * d) / (4 * n + 1);
      if (d <= floor_fx) begin
        d = floor_fx;
        m_ramp[a] = m_done[a];
      end
      if (m_done[a] >= m_total[a] / 2) m_ramp[a] = m_done[a];
    end else if (m_done[a] >= m_total[a] - m_ramp[a]) begin
      // mirrored ramp; holds once the index is back at zero
      if (m_idx[a] > 0) begin
        n = m_idx[a];
        d = (d * (4 * n + 1)) / (4 * n - 1);
        if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
        m_idx[a]--;
      end
    end
    m_ivfx[a] = d[31:0];
    m_cd[a] = scaled_countdown(a);
  endfunction

  function automatic sched_result_t predict_request(logic act, logic [2:0] ax,
      logic [23:0] raw, logic [15:0] start, logic [15:0] minv, logic [15:0] scl);
    sched_result_t r;
    logic [31:0] mag;
    r = '0;
    if (act == ACT_LOAD) begin
      if (ax < NAX) begin
        mag = raw[23] ? ((32'h100_0000 - {8'd0, raw}) & 32'h1FF_FFFF) : {8'd0, raw};
        if (mag > STEP_LIM) mag = STEP_LIM;
        m_dir[ax] = raw[23];
        m_total[ax] = mag;
        m_done[ax] = 0;
        m_ramp[ax] = 0;
        m_idx[ax] = 0;
        m_floor[ax] = minv;
        m_scale[ax] = scl;
        m_ivfx[ax] = {start, 16'd0};
        m_cd[ax] = scaled_countdown(ax);
        m_busy[ax] = (mag != 0);
      end
    end else begin
      for (int a = 0; a < NAX; a++) begin
        if (m_busy[a]) begin
          if (m_cd[a] > 0) m_cd[a]--;
          if (m_cd[a] == 0) begin
            step_one_axis(a);
            r.step_mask[a] = 1'b1;
          end
        end
      end
    end
    for (int a = 0; a < NAX; a++) begin
      r.dir_mask[a] = m_dir[a];
      r.busy_mask[a] = m_busy[a];
    end
    if (ax < NAX) r.position = m_pos[ax];
    r.all_done = (r.busy_mask == 0);
    return r;
  endfunction

  initial begin
    for (int a = 0; a < NAX; a++) begin
      m_pos[a] = 0; m_dir[a] = 0; m_total[a] = 0; m_done[a] = 0; m_ramp[a] = 0;
      m_idx[a] = 0; m_ivfx[a] = 0; m_cd[a] = 0; m_floor[a] = 0;
      m_scale[a] = SCALE_RESET; m_busy[a] = 0;
    end
  end

  // accept requests into the model, check results, watch for a hang
  always @(posedge clk_i) begin
    sched_result_t exp_r, got;
    if (in_valid_i && in_ready_o)
      pending_results.push_back(predict_request(action_i, axis_i, step_count_i,
          start_interval_i, min_interval_i, speed_scale_i));
    if (out_valid_o && out_ready_i) begin
      got = '{step_mask_o, dir_mask_o, busy_mask_o, axis_position_o, all_done_o};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.step_mask !== exp_r.step_mask)
          $display("%0t: step_mask exp %h got %h", $time, exp_r.step_mask, got.step_mask);
        if (got.dir_mask !== exp_r.dir_mask)
          $display("%0t: dir_mask exp %h got %h", $time, exp_r.dir_mask, got.dir_mask);
        if (got.busy_mask !== exp_r.busy_mask)
          $display("%0t: busy_mask exp %h got %h", $time, exp_r.busy_mask, got.busy_mask);
        if (got.position !== exp_r.position)
          $display("%0t: axis_position exp %0d got %0d", $time,
                   $signed(exp_r.position), $signed(got.position));
        if (got.all_done !== exp_r.all_done)
          $display("%0t: all_done exp %b got %b", $time, exp_r.all_done, got.all_done);
        if (got !== exp_r) errors++;
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver backpressure: mostly short stalls, a few long ones
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 3);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 1) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_request(logic act, logic [2:0] ax, logic [23:0] cnt,
      logic [15:0] start, logic [15:0] minv, logic [15:0] scl);
    int gap;
    in_valid_i <= 1'b1;
    action_i <= act;
    axis_i <= ax;
    step_count_i <= cnt;
    start_interval_i <= start;
    min_interval_i <= minv;
    speed_scale_i <= scl;
    do @(posedge clk_i); while (!in_ready_o);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_tick();
    send_request(ACT_TICK, 3'($urandom_range(0, 7)), 24'($urandom()),
                 16'($urandom()), 16'($urandom()), 16'($urandom()));
  endtask

  // extremes of every field, zero counts, out-of-range axes, zero interval
  task automatic test_field_extremes();
    send_tick();
    send_request(ACT_LOAD, 3'd0, 24'h80_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(ACT_LOAD, 3'd1, 24'h7F_FFFF, 16'd1, 16'd1, 16'd256);
    send_request(ACT_LOAD, 3'd2, 24'd0, 16'd5, 16'd2, 16'd256);
    send_request(ACT_LOAD, 3'd7, 24'd10, 16'd3, 16'd1, 16'd256);
    send_request(ACT_LOAD, 3'd5, 24'hFF_FFFF, 16'd3, 16'd1, 16'd256);
    send_request(ACT_LOAD, 3'd3, 24'hFF_FFFF, 16'd0, 16'd0, 16'd256);
    send_request(ACT_LOAD, 3'd4, 24'd6, 16'd2, 16'd9, 16'd300);
    repeat (6) send_tick();
    send_request(ACT_TICK, 3'd6, 24'd0, 16'd0, 16'd0, 16'd0);
    send_request(ACT_LOAD, 3'd0, 24'd0, 16'd0, 16'd0, 16'd0);
    send_request(ACT_LOAD, 3'd1, 24'hFF_FFF0, 16'd1, 16'd1, 16'd256);
  endtask

  // full moves on every axis until all are done: accel, cruise and decel
  task automatic test_short_moves();
    for (int a = 0; a < NAX; a++)
      send_request(ACT_LOAD, 3'(a), (a % 2) ? -24'(8 + 3 * a) : 24'(12 + 5 * a),
                   16'(4 + a), 16'(1 + a / 2), 16'(256 + 40 * a));
    for (int k = 0; k < 400 && !(pending_results.size() == 0 && all_done_o); k++)
      send_tick();
  endtask

  task automatic test_random_traffic(int count);
    logic [2:0] ax;
    int mag;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        send_tick();
      end else begin
        ax = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, NAX - 1));
        if ($urandom_range(0, 9) < 8) begin
          mag = $urandom_range(0, 60);
          send_request(ACT_LOAD, ax, $urandom_range(0, 1) ? -24'(mag) : 24'(mag),
                       16'($urandom_range(1, 30)), 16'($urandom_range(1, 12)),
                       16'($urandom_range(256, 520)));
        end else begin
          send_request(ACT_LOAD, ax, 24'($urandom()), 16'($urandom()),
                       16'($urandom()), 16'($urandom()));
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_short_moves();
    test_random_traffic(1000);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
